// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, off while reset is high
`define RBST_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbst assertion failed");

// implication checked on the following edge, off while reset is high
`define RBST_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbst assertion failed");

// holds on the edge after reset is seen, checked during reset too
`define RBST_ASSERT_RST(name, clk, rst, cons) \
  name: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("rbst assertion failed");

`endif

// ===== hdl/rbst_pkg.sv =====
// types, constants and helper functions for the ray/box slab test
// no dependencies; compiled before all other files
package rbst_pkg;

  localparam int CW = 32;           // coordinate width, signed fixed point
  localparam int PW = 2 * CW;       // full product width
  localparam int NUM_AXES = 3;
  localparam int NUM_REGS = 7;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int IN_BITS = 2 * NUM_AXES * CW;
  localparam int OUT_RAW_BITS = 2 * CW + 1;
  localparam int OUT_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int PAD_BITS = OUT_BITS - OUT_RAW_BITS;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] vec3_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_INV_DIR_X = 3'd3,
    REG_INV_DIR_Y = 3'd4,
    REG_INV_DIR_Z = 3'd5,
    REG_SIGN_BITS = 3'd6
  } reg_idx_t;

  // input beat: lower corner in the low half, axis x lowest
  typedef struct packed {
    vec3_t box_max;
    vec3_t box_min;
  } box_t;

  // per-axis entry and exit values
  typedef struct packed {
    vec3_t far_t;
    vec3_t near_t;
  } slab_t;

  // output beat: hit in bit 0
  typedef struct packed {
    logic [PAD_BITS-1:0] pad;
    coord_t              far_distance;
    coord_t              near_distance;
    logic                hit;
  } result_t;

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    if (d[CW] != d[CW-1]) begin
      sat_sub = d[CW] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_sub = d[CW-1:0];
    end
  endfunction

endpackage

// ===== hdl/rbst_diff.sv =====
// pipeline stage 1: picks near/far bounds per axis and subtracts the origin
// depends on rbst_pkg
module rbst_diff (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rbst_pkg::box_t                 box,
  input  rbst_pkg::vec3_t                origin,
  input  logic [rbst_pkg::NUM_AXES-1:0]  sign_bits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rbst_pkg::slab_t                diff
);
  import rbst_pkg::*;

  slab_t diff_next;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (sign_bits[i]) begin
        diff_next.near_t[i] = sat_sub(box.box_max[i], origin[i]);
        diff_next.far_t[i]  = sat_sub(box.box_min[i], origin[i]);
      end else begin
        diff_next.near_t[i] = sat_sub(box.box_min[i], origin[i]);
        diff_next.far_t[i]  = sat_sub(box.box_max[i], origin[i]);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      diff <= diff_next;
    end
  end

endmodule

// ===== hdl/rbst_scale.sv =====
// pipeline stages 2 and 3: multiply by the inverse direction, then
// drop fraction bits (floor) and saturate; depends on rbst_pkg
module rbst_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rbst_pkg::slab_t diff,
  input  rbst_pkg::vec3_t inv_dir,
  output logic            out_valid,
  input  logic            out_ready,
  output rbst_pkg::slab_t scaled
);
  import rbst_pkg::*;

  logic signed [PW-1:0] prod_near [NUM_AXES];
  logic signed [PW-1:0] prod_far  [NUM_AXES];
  logic                 prod_valid;
  logic                 prod_ready;
  slab_t                dist_next;

  function automatic coord_t scale(logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    // fits when the coordinate sign bit and all bits above it agree
    if ((&s[PW-1:CW-1]) || !(|s[PW-1:CW-1])) begin
      scale = s[CW-1:0];
    end else begin
      scale = s[PW-1] ? COORD_MIN : COORD_MAX;
    end
  endfunction

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prod_near[i] <= $signed(diff.near_t[i]) * $signed(inv_dir[i]);
        prod_far[i]  <= $signed(diff.far_t[i]) * $signed(inv_dir[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      dist_next.near_t[i] = scale(prod_near[i]);
      dist_next.far_t[i]  = scale(prod_far[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      scaled <= dist_next;
    end
  end

endmodule

// ===== hdl/rbst_merge.sv =====
// pipeline stages 4 and 5: intersects x with y, then with z, and builds
// the output beat; depends on rbst_pkg
module rbst_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbst_pkg::slab_t   scaled,
  output logic              out_valid,
  input  logic              out_ready,
  output rbst_pkg::result_t result
);
  import rbst_pkg::*;

  logic    xy_valid;
  logic    xy_ready;
  logic    xy_miss;
  coord_t  xy_tmin;
  coord_t  xy_tmax;
  coord_t  z_lo;
  coord_t  z_hi;
  logic    xy_miss_next;
  coord_t  xy_tmin_next;
  coord_t  xy_tmax_next;
  logic    miss_z;
  coord_t  tmin_z;
  coord_t  tmax_z;
  result_t result_next;

  always_comb begin
    xy_miss_next = ($signed(scaled.near_t[0]) > $signed(scaled.far_t[1])) ||
                   ($signed(scaled.near_t[1]) > $signed(scaled.far_t[0]));
    xy_tmin_next = ($signed(scaled.near_t[1]) > $signed(scaled.near_t[0])) ?
                   scaled.near_t[1] : scaled.near_t[0];
    xy_tmax_next = ($signed(scaled.far_t[1]) < $signed(scaled.far_t[0])) ?
                   scaled.far_t[1] : scaled.far_t[0];
  end

  assign xy_ready = !out_valid || out_ready;
  assign in_ready = !xy_valid || xy_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_valid <= 1'b0;
    end else if (in_ready) begin
      xy_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      xy_miss <= xy_miss_next;
      xy_tmin <= xy_tmin_next;
      xy_tmax <= xy_tmax_next;
      z_lo    <= scaled.near_t[2];
      z_hi    <= scaled.far_t[2];
    end
  end

  always_comb begin
    miss_z = xy_miss || ($signed(xy_tmin) > $signed(z_hi)) ||
             ($signed(z_lo) > $signed(xy_tmax));
    tmin_z = ($signed(z_lo) > $signed(xy_tmin)) ? z_lo : xy_tmin;
    tmax_z = ($signed(z_hi) < $signed(xy_tmax)) ? z_hi : xy_tmax;
    result_next = '0;
    // a hit also needs the exit point not behind the origin
    if (!miss_z && !tmax_z[CW-1]) begin
      result_next.hit           = 1'b1;
      result_next.near_distance = tmin_z;
      result_next.far_distance  = tmax_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (xy_ready) begin
      out_valid <= xy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (xy_valid && xy_ready) begin
      result <= result_next;
    end
  end

endmodule

// ===== hdl/ray_box_slab_test.sv =====
// ray_box_slab_test: ray versus axis-aligned box slab test, top level
// depends on rbst_pkg, rbst_diff, rbst_scale, rbst_merge
//
//   channel  dir  contents
//   s_*      in   one box per beat, lower and upper corners
//   m_*      out  hit flag, entry and exit distances
//   cfg_*    in   ray origin, inverse direction, axis sign bits
//
// one box per cycle sustained while m_tready stays high; an input beat reaches the output
// register through the stages subtract, multiply, scale, x/y merge, z merge
// each stage passes its beat on when the next one is empty or moving,
// so bubbles close up and a stall at m_tready backs up with no loss
// rst clears the stage valid bits and reloads the ray registers
module ray_box_slab_test #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [rbst_pkg::IN_BITS-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit, near_distance, far_distance, zero pad
  output logic [rbst_pkg::OUT_BITS-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [rbst_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [rbst_pkg::CW-1:0]         cfg_data
);
  import rbst_pkg::*;

  localparam logic [CW-1:0] INV_ONE = CW'(1) << FRAC_BITS;

  vec3_t                origin;
  vec3_t                inv_dir;
  logic [NUM_AXES-1:0]  sign_bits;

  logic    diff_valid;
  logic    diff_ready;
  slab_t   diff;
  logic    dist_valid;
  logic    dist_ready;
  slab_t   scaled;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin    <= '0;
      inv_dir   <= {NUM_AXES{INV_ONE}};
      sign_bits <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X:  origin[0]  <= cfg_data;
        REG_ORIGIN_Y:  origin[1]  <= cfg_data;
        REG_ORIGIN_Z:  origin[2]  <= cfg_data;
        REG_INV_DIR_X: inv_dir[0] <= cfg_data;
        REG_INV_DIR_Y: inv_dir[1] <= cfg_data;
        REG_INV_DIR_Z: inv_dir[2] <= cfg_data;
        REG_SIGN_BITS: sign_bits  <= cfg_data[NUM_AXES-1:0];
        default: ;
      endcase
    end
  end

  rbst_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .box       (box_t'(s_tdata)),
    .origin    (origin),
    .sign_bits (sign_bits),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .diff      (diff)
  );

  rbst_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .diff      (diff),
    .inv_dir   (inv_dir),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .scaled    (scaled)
  );

  rbst_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .scaled    (scaled),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = result;

endmodule

// ===== hdl/rbst_checker.sv =====
// port-level checks for ray_box_slab_test, attached by bind
// depends on rbst_pkg, assert_macros.svh and the top level
`include "assert_macros.svh"

module rbst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rbst_pkg::OUT_BITS-1:0] m_tdata
);
  import rbst_pkg::*;

  // a held output beat keeps its contents
  `RBST_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // a miss reports both distances as zero
  `RBST_ASSERT_IMP(a_miss_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[OUT_RAW_BITS-1:1] == '0)

  // a hit never exits behind the origin
  `RBST_ASSERT_IMP(a_hit_far_pos, clk, rst, m_tvalid && m_tdata[0], !m_tdata[OUT_RAW_BITS-1])

  // padding above the fields stays zero
  `RBST_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[OUT_BITS-1:OUT_RAW_BITS] == '0)

  // the pipeline comes out of reset empty
  `RBST_ASSERT_RST(a_rst_empty, clk, rst, !m_tvalid)

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/tb.sv =====
// testbench for ray_box_slab_test: streams boxes against several rays and
// checks every result beat against a slab predictor kept in step here
// depends on rbst_pkg and the ray_box_slab_test top level
`timescale 1ns / 100ps

module tb;
  import rbst_pkg::*;

  localparam int FRAC = 16;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam coord_t ONE = 32'sh0001_0000;
  localparam coord_t NEG_ONE = -32'sh0001_0000;
  localparam coord_t NEG_HALF = -32'sh0000_8000;
  localparam int HOLD_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;   // box_min x/y/z, box_max x/y/z
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;       // hit, near_distance, far_distance, pad
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  // ray as the block should hold it
  coord_t ray_org [NUM_AXES];
  coord_t ray_inv [NUM_AXES];
  logic [NUM_AXES-1:0] ray_sign;

  result_t slab_due [$];
  int errors = 0;
  logic steady = 1'b0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;

  ray_box_slab_test #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic coord_t clamp_coord(longint v);
    if (v > SAT_HI) return COORD_MAX;
    if (v < SAT_LO) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // (bound - origin) saturated, times inverse direction, floor-shifted, saturated
  function automatic coord_t axis_param(coord_t bound, int i);
    longint d;
    longint p;
    d = longint'(clamp_coord(longint'(bound) - longint'(ray_org[i])));
    p = (d * longint'(ray_inv[i])) >>> FRAC;
    return clamp_coord(p);
  endfunction

  function automatic result_t slab_predict(box_t b);
    coord_t t_near [NUM_AXES];
    coord_t t_far [NUM_AXES];
    coord_t tn;
    coord_t tf;
    logic ok;
    result_t r;
    int i;
    for (i = 0; i < NUM_AXES; i++) begin
      t_near[i] = axis_param(ray_sign[i] ? b.box_max[i] : b.box_min[i], i);
      t_far[i] = axis_param(ray_sign[i] ? b.box_min[i] : b.box_max[i], i);
    end
    tn = t_near[0];
    tf = t_far[0];
    ok = 1'b1;
    for (i = 1; i < NUM_AXES && ok; i++) begin
      if (tn > t_far[i] || t_near[i] > tf) begin
        ok = 1'b0;
      end else begin
        if (t_near[i] > tn) tn = t_near[i];
        if (t_far[i] < tf) tf = t_far[i];
      end
    end
    if (ok && tf < 0) ok = 1'b0;
    r = '0;
    r.hit = ok;
    r.near_distance = ok ? tn : '0;
    r.far_distance = ok ? tf : '0;
    return r;
  endfunction

  function automatic void note_write(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
    case (idx)
      REG_ORIGIN_X: ray_org[0] = val;
      REG_ORIGIN_Y: ray_org[1] = val;
      REG_ORIGIN_Z: ray_org[2] = val;
      REG_INV_DIR_X: ray_inv[0] = val;
      REG_INV_DIR_Y: ray_inv[1] = val;
      REG_INV_DIR_Z: ray_inv[2] = val;
      REG_SIGN_BITS: ray_sign = val[NUM_AXES-1:0];
      default: ;
    endcase
  endfunction

  function automatic vec3_t v3(coord_t x, coord_t y, coord_t z);
    return {z, y, x};
  endfunction

  function automatic box_t make_box(vec3_t mn, vec3_t mx);
    box_t b;
    b.box_min = mn;
    b.box_max = mx;
    return b;
  endfunction

  function automatic box_t cube(coord_t lo, coord_t hi);
    return make_box(v3(lo, lo, lo), v3(hi, hi, hi));
  endfunction

  function automatic box_t wild_box();
    return make_box(v3($urandom, $urandom, $urandom), v3($urandom, $urandom, $urandom));
  endfunction

  // box near the ray origin; with hug set it encloses the origin on every axis
  function automatic box_t near_box(logic hug);
    vec3_t mn;
    vec3_t mx;
    int h;
    int off;
    coord_t c;
    int i;
    for (i = 0; i < NUM_AXES; i++) begin
      h = $urandom_range(1 << 20, 1);
      off = hug ? int'($urandom_range(2 * h)) - h : int'($urandom_range(1 << 22)) - (1 << 21);
      c = ray_org[i] + off;
      mn[i] = c - h;
      mx[i] = c + h;
    end
    return make_box(mn, mx);
  endfunction

  task automatic send_box(box_t b);
    // unless steady, an idle gap may go in before each box, starting and growing with chance 21 in a hundred
    while (!steady && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    slab_due.insert(slab_due.size(), slab_predict(b));
  endtask

  // block goes idle: input dropped, every result back, pipeline flushed
  task automatic settle();
    s_tvalid <= 1'b0;
    while (slab_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    note_write(idx, val);
  endtask

  task automatic set_ray(vec3_t org, vec3_t inv, logic [CW-1:0] signs);
    write_reg(REG_ORIGIN_X, org[0]);
    write_reg(REG_ORIGIN_Y, org[1]);
    write_reg(REG_ORIGIN_Z, org[2]);
    write_reg(REG_INV_DIR_X, inv[0]);
    write_reg(REG_INV_DIR_Y, inv[1]);
    write_reg(REG_INV_DIR_Z, inv[2]);
    write_reg(REG_SIGN_BITS, signs);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // origin within +-16, inverse direction 1/16..16 with random sign, now and then zero
  task automatic set_sane_ray();
    vec3_t org;
    vec3_t inv;
    logic [CW-1:0] signs;
    int mag;
    int i;
    signs = $urandom & ~32'h7;
    for (i = 0; i < NUM_AXES; i++) begin
      org[i] = int'($urandom_range(1 << 21)) - (1 << 20);
      mag = ($urandom_range(15) == 0) ? 0 : $urandom_range(1 << 20, 1 << 12);
      signs[i] = $urandom_range(1);
      inv[i] = signs[i] ? -mag : mag;
    end
    set_ray(org, inv, signs);
  endtask

  task automatic send_sane_boxes(int n);
    int k;
    int pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      if (pick == 0) send_box(wild_box());
      else send_box(near_box(pick < 5));
    end
  endtask

  task automatic test_default_ray();
    send_box(cube(NEG_ONE, ONE));
    send_box(cube(2 * ONE, 3 * ONE));
    send_box(cube(-3 * ONE, -2 * ONE));
    // x and y slabs apart
    send_box(make_box(v3(ONE, 5 * ONE, ONE), v3(2 * ONE, 6 * ONE, 2 * ONE)));
    // z slab apart from the x/y overlap
    send_box(make_box(v3(ONE, ONE, 5 * ONE), v3(3 * ONE, 3 * ONE, 6 * ONE)));
    send_box(cube(COORD_MIN, COORD_MAX));
    send_box(cube(2 * ONE, ONE));
    send_box(cube('0, '0));
    send_box(cube(COORD_MAX, COORD_MAX));
    send_box(cube(COORD_MIN, COORD_MIN));
  endtask

  task automatic test_edge_rays();
    settle();
    // saturating differences and products; upper sign bits set but ignored
    set_ray(v3(COORD_MAX, COORD_MIN, '0), v3(COORD_MIN, COORD_MAX, '0), 32'hFFFF_FFFD);
    write_reg(REG_UNUSED, 32'h1234_5678);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_box(cube(COORD_MIN, COORD_MAX));
    send_box(cube('0, '0));
    send_box(cube(COORD_MAX, COORD_MIN));
    send_box(cube(NEG_ONE, ONE));
    settle();
    // negative directions; z at -0.5 so odd differences round down
    set_ray(v3('0, '0, '0), v3(NEG_ONE, NEG_ONE, NEG_HALF), 32'd7);
    send_box(cube(ONE, 2 * ONE));
    send_box(cube(-2 * ONE, NEG_ONE));
    send_box(make_box(v3(-3 * ONE, -3 * ONE, -32'sd3), v3(32'sd1, 32'sd1, 32'sd1)));
    send_box(make_box(v3(-32'sd5, -32'sd5, -32'sd7), v3(32'sd3, 32'sd3, 32'sd9)));
  endtask

  task automatic test_sane_rays();
    repeat (5) begin
      settle();
      set_sane_ray();
      send_sane_boxes(80);
    end
  endtask

  task automatic test_wild_rays();
    repeat (3) begin
      settle();
      set_ray(v3($urandom, $urandom, $urandom), v3($urandom, $urandom, $urandom), $urandom);
      repeat (40) send_box(wild_box());
    end
  endtask

  task automatic test_backpressure();
    settle();
    set_sane_ray();
    hold_asked++;
    send_sane_boxes(40);
  endtask

  task automatic test_steady_stream();
    settle();
    set_sane_ray();
    steady = 1'b1;
    send_sane_boxes(80);
    steady = 1'b0;
  endtask

  // result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (slab_due.size() == 0) begin
        $display("%0t: result beat with none expected, got hit %0d near %0d far %0d",
                 $time, got.hit, got.near_distance, got.far_distance);
        errors++;
      end else begin
        want = slab_due.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.near_distance !== want.near_distance) begin
          $display("%0t: near_distance expected %0d got %0d",
                   $time, want.near_distance, got.near_distance);
          errors++;
        end
        if (got.far_distance !== want.far_distance) begin
          $display("%0t: far_distance expected %0d got %0d",
                   $time, want.far_distance, got.far_distance);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    ray_org = '{default: '0};
    ray_inv = '{default: ONE};
    ray_sign = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_ray();
    test_edge_rays();
    test_sane_rays();
    test_wild_rays();
    test_backpressure();
    test_steady_stream();
    settle();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
